### hw/rtl/hrd_pkg.sv
// ----------------------------------------------------------------------------
// hrd_pkg
// Types and constants shared by the response deframer modules
// ----------------------------------------------------------------------------
package hrd_pkg;

    localparam int CAP_W   = 24;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 64;
    localparam int OC_W    = 3;
    localparam int PH_W    = 3;
    localparam int MI_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(4096);

    // parse phases
    localparam logic [PH_W-1:0] PH_VER  = 3'd0;
    localparam logic [PH_W-1:0] PH_CODE = 3'd1;
    localparam logic [PH_W-1:0] PH_REST = 3'd2;
    localparam logic [PH_W-1:0] PH_HDR  = 3'd3;
    localparam logic [PH_W-1:0] PH_BODY = 3'd4;
    localparam logic [PH_W-1:0] PH_DONE = 3'd5;

    // match positions for the header prefix, the length value and the status code
    localparam logic [MI_W-1:0] MI_PREFIX_LAST = 5'd15;
    localparam logic [MI_W-1:0] MI_VALUE       = 5'd16;
    localparam logic [MI_W-1:0] MI_PLUS        = 5'd17;
    localparam logic [MI_W-1:0] MI_ZERO        = 5'd18;
    localparam logic [MI_W-1:0] MI_DIGITS      = 5'd19;
    localparam logic [MI_W-1:0] MI_OTHER       = 5'd31;
    localparam logic [MI_W-1:0] MI_CODE_LEN    = 5'd3;
    localparam logic [MI_W-1:0] MI_CODE_SAT    = 5'd4;

    // outcome codes
    localparam logic [OC_W-1:0] OC_OK        = 3'd0;
    localparam logic [OC_W-1:0] OC_NO_TOKEN  = 3'd1;
    localparam logic [OC_W-1:0] OC_NOT_200   = 3'd2;
    localparam logic [OC_W-1:0] OC_MALFORMED = 3'd3;
    localparam logic [OC_W-1:0] OC_SHORT     = 3'd4;
    localparam logic [OC_W-1:0] OC_NO_SPACE  = 3'd5;

    // characters
    localparam logic [BYTE_W-1:0] CH_SP   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
    localparam logic [BYTE_W-1:0] CH_PLUS = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

    localparam int RET_BYTES = WORD_W / BYTE_W;

    localparam logic [16*BYTE_W-1:0] LEN_PREFIX = "Content-Length: ";
    localparam logic [3*BYTE_W-1:0]  OK_CODE    = "200";

    typedef struct packed {
        logic [BYTE_W-1:0]        payload_byte;
        logic                     payload_valid;
        logic                     finished;
        logic [OC_W-1:0]          outcome;
        logic signed [WORD_W-1:0] return_word;
    } t_result;

    function automatic logic [BYTE_W-1:0] prefix_char(input logic [3:0] idx);
        logic [3:0] rev;
        rev = 4'd15 - idx;
        return LEN_PREFIX[rev*BYTE_W +: BYTE_W];
    endfunction

    function automatic logic [BYTE_W-1:0] code_char(input logic [1:0] idx);
        logic [1:0] rev;
        rev = 2'd2 - idx;
        return OK_CODE[rev*BYTE_W +: BYTE_W];
    endfunction

endpackage

### hw/rtl/hrd_in_if.sv
// ----------------------------------------------------------------------------
// hrd_in_if
// Byte channel carrying the received response, one byte per beat
// ----------------------------------------------------------------------------
interface hrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       final_byte;

    modport source (output valid, output raw_byte, output final_byte, input ready);
    modport sink   (input valid, input raw_byte, input final_byte, output ready);
endinterface

### hw/rtl/hrd_out_if.sv
// ----------------------------------------------------------------------------
// hrd_out_if
// Result channel: payload bytes and the closing status beat
// ----------------------------------------------------------------------------
interface hrd_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         payload_byte;
    logic               payload_valid;
    logic               finished;
    logic [2:0]         outcome;
    logic signed [63:0] return_word;

    modport source (output valid, output payload_byte, output payload_valid,
                    output finished, output outcome, output return_word, input ready);
    modport sink   (input valid, input payload_byte, input payload_valid,
                    input finished, input outcome, input return_word, output ready);
endinterface

### hw/rtl/hrd_cfg_if.sv
// ----------------------------------------------------------------------------
// hrd_cfg_if
// Configuration write channel for the payload capacity register
// ----------------------------------------------------------------------------
interface hrd_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] payload_capacity;

    modport source (output valid, output payload_capacity, input ready);
    modport sink   (input valid, input payload_capacity, output ready);
endinterface

### hw/rtl/hrd_parse_core.sv
// ----------------------------------------------------------------------------
// hrd_parse_core
// Per-byte parse state machine: status line, headers, length and body
// ----------------------------------------------------------------------------
module hrd_parse_core #(
    parameter int HEADER_SLACK = 1024,
    parameter int LENGTH_BITS  = 31
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [7:0]                i_raw_byte,
    input  logic                      i_final_byte,
    input  logic [hrd_pkg::CAP_W-1:0] i_capacity,
    output logic                      o_has_result,
    output hrd_pkg::t_result          o_result
);
    import hrd_pkg::*;

    localparam int RAW_W = $clog2((1 << CAP_W) + HEADER_SLACK + 1);
    localparam int LEN_W = LENGTH_BITS;
    localparam int CNT_W = LENGTH_BITS + 1;
    localparam int MUL_W = LENGTH_BITS + 4;
    localparam int CMP_W = ((LEN_W > CAP_W) ? LEN_W : CAP_W) + 1;
    localparam logic [MUL_W-1:0] LEN_LIMIT = MUL_W'({LEN_W{1'b1}});
    localparam logic [CNT_W-1:0] CNT_SAT   = {CNT_W{1'b1}};
    localparam logic [CMP_W-1:0] RET_LEN   = CMP_W'(RET_BYTES);

    logic [PH_W-1:0]   r_phase,       n_phase;
    logic [MI_W-1:0]   r_match_index, n_match_index;
    logic              r_status_ok,   n_status_ok;
    logic              r_skip_next,   n_skip_next;
    logic              r_line_empty,  n_line_empty;
    logic [LEN_W-1:0]  r_length,      n_length;
    logic              r_length_seen, n_length_seen;
    logic              r_length_bad,  n_length_bad;
    logic [CNT_W-1:0]  r_body_count,  n_body_count;
    logic [WORD_W-1:0] r_value_shift, n_value_shift;
    logic [RAW_W-1:0]  r_raw_count,   n_raw_count;
    logic [OC_W-1:0]   r_error_code,  n_error_code;

    logic [RAW_W-1:0]  w_limit;
    logic [7:0]        w_c;
    logic              w_digit;
    logic [MUL_W-1:0]  w_len_x10;
    logic [CMP_W-1:0]  w_cap_plus;
    logic [CMP_W-1:0]  w_len_ext;
    logic [CMP_W-1:0]  w_n_len_ext;
    logic              w_allowed;
    logic              w_emit;
    logic [OC_W-1:0]   w_outcome;

    assign w_c         = i_raw_byte;
    assign w_limit     = RAW_W'(i_capacity) + RAW_W'(HEADER_SLACK);
    assign w_digit     = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_len_x10   = (MUL_W'(r_length) << 3) + (MUL_W'(r_length) << 1)
                         + MUL_W'(w_c - CH_0);
    assign w_cap_plus  = CMP_W'(i_capacity) + RET_LEN;
    assign w_len_ext   = CMP_W'(r_length);
    assign w_n_len_ext = CMP_W'(n_length);
    assign w_allowed   = (r_error_code == OC_OK) && r_length_seen
                         && (w_len_ext >= RET_LEN) && (w_len_ext <= w_cap_plus);

    always_comb begin
        n_phase       = r_phase;
        n_match_index = r_match_index;
        n_status_ok   = r_status_ok;
        n_skip_next   = r_skip_next;
        n_line_empty  = r_line_empty;
        n_length      = r_length;
        n_length_seen = r_length_seen;
        n_length_bad  = r_length_bad;
        n_body_count  = r_body_count;
        n_value_shift = r_value_shift;
        n_raw_count   = r_raw_count;
        n_error_code  = r_error_code;
        w_emit        = 1'b0;
        w_outcome     = OC_OK;

        if (i_step && (r_raw_count < w_limit)) begin
            n_raw_count = r_raw_count + 1'b1;
            unique case (r_phase)
                PH_VER: begin
                    if (w_c == CH_SP) begin
                        n_phase       = PH_CODE;
                        n_match_index = '0;
                        n_status_ok   = 1'b1;
                    end else if (w_c == CH_CR) begin
                        n_error_code = OC_NO_TOKEN;
                        n_phase      = PH_DONE;
                    end
                end
                PH_CODE: begin
                    if ((w_c == CH_SP) || (w_c == CH_CR)) begin
                        if (!(r_status_ok && (r_match_index == MI_CODE_LEN))) begin
                            n_error_code = OC_NOT_200;
                            n_phase      = PH_DONE;
                        end else if (w_c == CH_SP) begin
                            n_phase = PH_REST;
                        end else begin
                            n_phase       = PH_HDR;
                            n_skip_next   = 1'b1;
                            n_line_empty  = 1'b1;
                            n_match_index = '0;
                            n_length_bad  = 1'b0;
                        end
                    end else begin
                        if ((r_match_index >= MI_CODE_LEN)
                            || (w_c != code_char(r_match_index[1:0]))) begin
                            n_status_ok = 1'b0;
                        end
                        if (r_match_index < MI_CODE_SAT) begin
                            n_match_index = r_match_index + 1'b1;
                        end
                    end
                end
                PH_REST: begin
                    if (w_c == CH_CR) begin
                        n_phase       = PH_HDR;
                        n_skip_next   = 1'b1;
                        n_line_empty  = 1'b1;
                        n_match_index = '0;
                        n_length_bad  = 1'b0;
                    end
                end
                PH_HDR: begin
                    if (r_skip_next) begin
                        n_skip_next = 1'b0;
                    end else if (w_c == CH_CR) begin
                        if (r_line_empty) begin
                            if (!r_length_seen) begin
                                n_error_code = OC_MALFORMED;
                                n_phase      = PH_DONE;
                            end else begin
                                n_phase     = PH_BODY;
                                n_skip_next = 1'b1;
                            end
                        end else if ((r_match_index >= MI_VALUE) && (r_match_index != MI_OTHER)
                                     && (r_length_bad || (r_match_index < MI_ZERO))) begin
                            n_error_code = OC_MALFORMED;
                            n_phase      = PH_DONE;
                        end else begin
                            if ((r_match_index >= MI_VALUE) && (r_match_index != MI_OTHER)) begin
                                n_length_seen = 1'b1;
                            end
                            n_skip_next   = 1'b1;
                            n_line_empty  = 1'b1;
                            n_match_index = '0;
                            n_length_bad  = 1'b0;
                        end
                    end else begin
                        n_line_empty = 1'b0;
                        if (r_match_index < MI_VALUE) begin
                            if (w_c == prefix_char(r_match_index[3:0])) begin
                                n_match_index = r_match_index + 1'b1;
                                if (r_match_index == MI_PREFIX_LAST) begin
                                    n_length     = '0;
                                    n_length_bad = 1'b0;
                                end
                            end else begin
                                n_match_index = MI_OTHER;
                            end
                        end else if ((r_match_index != MI_OTHER) && !r_length_bad) begin
                            if ((w_c == CH_PLUS) && (r_match_index == MI_VALUE)) begin
                                n_match_index = MI_PLUS;
                            end else if (w_digit) begin
                                if (r_match_index == MI_ZERO) begin
                                    n_length_bad = 1'b1;
                                end else if ((r_match_index == MI_VALUE)
                                             || (r_match_index == MI_PLUS)) begin
                                    n_length      = LEN_W'(w_c - CH_0);
                                    n_match_index = (w_c == CH_0) ? MI_ZERO : MI_DIGITS;
                                end else if (w_len_x10 > LEN_LIMIT) begin
                                    n_length_bad = 1'b1;
                                end else begin
                                    n_length = w_len_x10[LEN_W-1:0];
                                end
                            end else begin
                                n_length_bad = 1'b1;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (r_skip_next) begin
                        n_skip_next = 1'b0;
                    end else begin
                        if (r_body_count < CNT_W'(RET_BYTES)) begin
                            n_value_shift[r_body_count[2:0]*BYTE_W +: BYTE_W] = w_c;
                        end else if ((r_body_count < CNT_W'(r_length)) && w_allowed) begin
                            w_emit = 1'b1;
                        end
                        if (r_body_count != CNT_SAT) begin
                            n_body_count = r_body_count + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        unique case (n_phase)
            PH_VER:  w_outcome = OC_NO_TOKEN;
            PH_CODE: w_outcome = (n_status_ok && (n_match_index == MI_CODE_LEN))
                                 ? OC_MALFORMED : OC_NOT_200;
            PH_REST: w_outcome = OC_MALFORMED;
            PH_HDR:  w_outcome = OC_MALFORMED;
            PH_BODY: begin
                if (!n_length_seen || (n_body_count < CNT_W'(n_length))) begin
                    w_outcome = OC_MALFORMED;
                end else if (w_n_len_ext < RET_LEN) begin
                    w_outcome = OC_SHORT;
                end else if (w_n_len_ext > w_cap_plus) begin
                    w_outcome = OC_NO_SPACE;
                end else begin
                    w_outcome = OC_OK;
                end
            end
            default: w_outcome = n_error_code;
        endcase
    end

    assign o_has_result           = i_step && (w_emit || i_final_byte);
    assign o_result.payload_byte  = w_emit ? w_c : 8'd0;
    assign o_result.payload_valid = w_emit;
    assign o_result.finished      = i_final_byte;
    assign o_result.outcome       = i_final_byte ? w_outcome : OC_OK;
    assign o_result.return_word   = (i_final_byte && (w_outcome == OC_OK))
                                    ? $signed(n_value_shift) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_final_byte)) begin
            r_phase       <= PH_VER;
            r_match_index <= '0;
            r_status_ok   <= 1'b0;
            r_skip_next   <= 1'b0;
            r_line_empty  <= 1'b1;
            r_length      <= '0;
            r_length_seen <= 1'b0;
            r_length_bad  <= 1'b0;
            r_body_count  <= '0;
            r_value_shift <= '0;
            r_raw_count   <= '0;
            r_error_code  <= OC_OK;
        end else begin
            r_phase       <= n_phase;
            r_match_index <= n_match_index;
            r_status_ok   <= n_status_ok;
            r_skip_next   <= n_skip_next;
            r_line_empty  <= n_line_empty;
            r_length      <= n_length;
            r_length_seen <= n_length_seen;
            r_length_bad  <= n_length_bad;
            r_body_count  <= n_body_count;
            r_value_shift <= n_value_shift;
            r_raw_count   <= n_raw_count;
            r_error_code  <= n_error_code;
        end
    end

endmodule

### hw/rtl/hrd_result_reg.sv
// ----------------------------------------------------------------------------
// hrd_result_reg
// Output register holding one result beat until the consumer takes it
// ----------------------------------------------------------------------------
module hrd_result_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  hrd_pkg::t_result i_result,
    output logic             o_free,
    hrd_out_if.source        o_out
);
    import hrd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out.valid         = r_valid;
    assign o_out.payload_byte  = r_result.payload_byte;
    assign o_out.payload_valid = r_result.payload_valid;
    assign o_out.finished      = r_result.finished;
    assign o_out.outcome       = r_result.outcome;
    assign o_out.return_word   = r_result.return_word;

endmodule

### hw/rtl/http_response_deframer_unit.sv
// ----------------------------------------------------------------------------
// http_response_deframer_unit
// Deframes an HTTP response byte stream into payload bytes and a status beat
// ----------------------------------------------------------------------------
// One response byte is taken per beat, and one byte per clock is sustained
// while the output is not stalled. Each byte passes an input register, the
// parse state machine and an output register, which holds its result beat.
// While a beat waits on a stalled output, the next byte is held in the input
// register, whether or not it produces a beat. A beat
// is produced for every payload byte and for the byte marked final, which
// carries the outcome and the little-endian return value; bytes that only
// advance the parse produce no beat. Payload bytes already sent before an
// error is found are not withdrawn. The capacity register may only be
// written while no response is in flight.
module http_response_deframer_unit #(
    parameter int HEADER_SLACK = 1024,
    parameter int LENGTH_BITS  = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hrd_in_if.sink    i_in,
    hrd_out_if.source o_out,
    hrd_cfg_if.sink   i_cfg
);
    import hrd_pkg::*;

    logic             r_in_valid;
    logic [7:0]       r_raw_byte;
    logic             r_final_byte;
    logic [CAP_W-1:0] r_capacity;

    logic             w_step;
    logic             w_free;
    logic             w_has_result;
    t_result          w_result;

    assign w_step     = r_in_valid && w_free;
    assign i_in.ready = !r_in_valid || w_step;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_raw_byte   <= i_in.raw_byte;
            r_final_byte <= i_in.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_capacity <= i_cfg.payload_capacity;
        end
    end

    hrd_parse_core #(
        .HEADER_SLACK (HEADER_SLACK),
        .LENGTH_BITS  (LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_step),
        .i_raw_byte   (r_raw_byte),
        .i_final_byte (r_final_byte),
        .i_capacity   (r_capacity),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    hrd_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_has_result),
        .i_result (w_result),
        .o_free   (w_free),
        .o_out    (o_out)
    );

`ifndef SYNTH
    a_held_byte_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_free |=> r_in_valid && $stable(r_raw_byte))
        else $error("held input byte lost while output stalled");

    a_result_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_has_result |-> w_free && w_step)
        else $error("result produced without room in output register");

    a_status_only_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.finished |-> o_out.outcome == OC_OK && o_out.return_word == '0)
        else $error("status fields set on a payload-only beat");

    a_word_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.outcome != OC_OK |-> o_out.return_word == '0)
        else $error("return value reported with an error outcome");
`endif

endmodule
